[hdl/qar_pkg.sv]
package qar_pkg;

    localparam int IN_BITS_DEF       = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int LANES             = 4;

    // per-request control that travels down the pipeline
    // neg holds the final sign of each result lane in order w, x, y, z
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } t_ctl;

endpackage

[hdl/qar_req_if.sv]
interface qar_req_if #(
    parameter int IN_BITS = 16
);
    logic                      valid;
    logic                      ready;
    logic signed [IN_BITS-1:0] in_w;
    logic signed [IN_BITS-1:0] in_x;
    logic signed [IN_BITS-1:0] in_y;
    logic signed [IN_BITS-1:0] in_z;

    modport source (output valid, in_w, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_w, in_x, in_y, in_z, output ready);
endinterface

[hdl/qar_rsp_if.sv]
interface qar_rsp_if #(
    parameter int OUT_FRAC_BITS = 14
);
    logic                              valid;
    logic                              ready;
    logic signed [OUT_FRAC_BITS+1:0]   out_w;
    logic signed [OUT_FRAC_BITS+1:0]   out_x;
    logic signed [OUT_FRAC_BITS+1:0]   out_y;
    logic signed [OUT_FRAC_BITS+1:0]   out_z;
    logic                              zero_length;

    modport source (output valid, out_w, out_x, out_y, out_z, zero_length, input ready);
    modport sink   (input valid, out_w, out_x, out_y, out_z, zero_length, output ready);
endinterface

[hdl/qar_front.sv]
module qar_front
    import qar_pkg::*;
#(
    parameter int IN_BITS       = IN_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    localparam int NW = 2*IN_BITS + 2,
    localparam int AW = 2*IN_BITS + 2*OUT_FRAC_BITS + 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [IN_BITS-1:0] i_w,
    input  logic signed [IN_BITS-1:0] i_x,
    input  logic signed [IN_BITS-1:0] i_y,
    input  logic signed [IN_BITS-1:0] i_z,
    output t_ctl                      o_ctl,
    output logic [NW-1:0]             o_n,
    output logic [AW-1:0]             o_m [LANES]
);
    localparam int  SQW    = 2*IN_BITS;
    localparam bit  BIG_EN = (IN_BITS >= 32);

    logic [IN_BITS-1:0] in_v  [LANES];
    logic [IN_BITS-1:0] abs_v [LANES];
    logic [LANES-1:0]   in_neg;
    logic               big;

    logic               r_v1, r_v2;
    logic [LANES-1:0]   r_neg1, r_neg2;
    logic [IN_BITS-1:0] r_mag [LANES];
    logic [SQW-1:0]     r_sq  [LANES];

    logic [NW-1:0]      n_sum;
    logic               trace_pos, flip;
    t_ctl               n_ctl, r_ctl;
    logic [NW-1:0]      r_n;
    logic [AW-1:0]      r_m [LANES];

    assign in_v[0] = i_w;
    assign in_v[1] = i_x;
    assign in_v[2] = i_y;
    assign in_v[3] = i_z;

    always_comb begin
        big = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            in_neg[i] = in_v[i][IN_BITS-1];
            abs_v[i]  = in_neg[i] ? (~in_v[i] + 1'b1) : in_v[i];
            if (BIG_EN && abs_v[i][IN_BITS-1]) begin
                big = 1'b1;
            end
        end
    end

    // stage 1: magnitudes; when IN_BITS >= 32, a full-scale negative halves all four
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_neg1 <= in_neg;
            for (int i = 0; i < LANES; i++) begin
                r_mag[i] <= big ? (abs_v[i] >> 1) : abs_v[i];
            end
        end
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_neg2 <= r_neg1;
            for (int i = 0; i < LANES; i++) begin
                r_sq[i] <= r_mag[i] * r_mag[i];
            end
        end
    end

    // stage 3: length squared and branch choice
    always_comb begin
        n_sum = NW'(r_sq[0]) + NW'(r_sq[1]) + NW'(r_sq[2]) + NW'(r_sq[3]);
        trace_pos = NW'(r_sq[0]) > (n_sum >> 2);
        if (trace_pos) begin
            flip = r_neg2[0];
        end else if (r_sq[1] > r_sq[3] && r_sq[1] > r_sq[2]) begin
            flip = r_neg2[1];
        end else if (r_sq[3] > r_sq[2]) begin
            flip = r_neg2[3];
        end else begin
            flip = !r_neg2[2];
        end
        n_ctl.valid  = r_v2;
        n_ctl.zero   = (n_sum == '0);
        // remapped order is (w, x, z, -y)
        n_ctl.neg[0] = r_neg2[0] ^ flip;
        n_ctl.neg[1] = r_neg2[1] ^ flip;
        n_ctl.neg[2] = r_neg2[3] ^ flip;
        n_ctl.neg[3] = (!r_neg2[2]) ^ flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_en) begin
            r_ctl.zero <= n_ctl.zero;
            r_ctl.neg  <= n_ctl.neg;
            r_n        <= n_sum;
            r_m[0]     <= AW'(r_sq[0]) << (2*OUT_FRAC_BITS + 2);
            r_m[1]     <= AW'(r_sq[1]) << (2*OUT_FRAC_BITS + 2);
            r_m[2]     <= AW'(r_sq[3]) << (2*OUT_FRAC_BITS + 2);
            r_m[3]     <= AW'(r_sq[2]) << (2*OUT_FRAC_BITS + 2);
        end
    end

    assign o_ctl = r_ctl;
    assign o_n   = r_n;
    assign o_m   = r_m;

endmodule

[hdl/qar_step.sv]
module qar_step
    import qar_pkg::*;
#(
    parameter int IN_BITS       = IN_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    parameter int BIT_POS       = 0,
    localparam int NW = 2*IN_BITS + 2,
    localparam int AW = 2*IN_BITS + 2*OUT_FRAC_BITS + 6,
    localparam int RW = OUT_FRAC_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [NW-1:0] i_n,
    input  logic [AW-1:0] i_m [LANES],
    input  logic [AW-1:0] i_a [LANES],
    input  logic [AW-1:0] i_b [LANES],
    input  logic [RW-1:0] i_r [LANES],
    output t_ctl          o_ctl,
    output logic [NW-1:0] o_n,
    output logic [AW-1:0] o_m [LANES],
    output logic [AW-1:0] o_a [LANES],
    output logic [AW-1:0] o_b [LANES],
    output logic [RW-1:0] o_r [LANES]
);
    logic [AW-1:0] n_ext;
    logic [AW-1:0] a_try [LANES];
    logic [AW-1:0] b_try [LANES];
    logic [AW-1:0] lhs   [LANES];
    logic [AW-1:0] n_a   [LANES];
    logic [AW-1:0] n_b   [LANES];
    logic [RW-1:0] n_r   [LANES];

    t_ctl          r_ctl;
    logic [NW-1:0] r_n;
    logic [AW-1:0] r_m [LANES];
    logic [AW-1:0] r_a [LANES];
    logic [AW-1:0] r_b [LANES];
    logic [RW-1:0] r_r [LANES];

    // trial r' = r + 2^k, a = r^2*n and b = r*n kept by shifts and adds
    // accept when (2r'-1)^2 * n <= mag^2 * 4^(F+1)
    always_comb begin
        n_ext = AW'(i_n);
        for (int l = 0; l < LANES; l++) begin
            a_try[l] = i_a[l] + (i_b[l] << (BIT_POS + 1)) + (n_ext << (2*BIT_POS));
            b_try[l] = i_b[l] + (n_ext << BIT_POS);
            lhs[l]   = ((a_try[l] - b_try[l]) << 2) + n_ext;
            if (lhs[l] <= i_m[l]) begin
                n_a[l] = a_try[l];
                n_b[l] = b_try[l];
                n_r[l] = i_r[l] | (RW'(1) << BIT_POS);
            end else begin
                n_a[l] = i_a[l];
                n_b[l] = i_b[l];
                n_r[l] = i_r[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_n <= i_n;
            r_m <= i_m;
            r_a <= n_a;
            r_b <= n_b;
            r_r <= n_r;
        end
    end

    assign o_ctl = r_ctl;
    assign o_n   = r_n;
    assign o_m   = r_m;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_r   = r_r;

endmodule

[hdl/quaternion_axis_remap_core.sv]
// channel | port  | dir | payload
// --------+-------+-----+--------------------------------------------
// request | i_req | in  | in_w, in_x, in_y, in_z (IN_BITS signed)
// result  | o_rsp | out | out_w..out_z (Q1.OUT_FRAC_BITS), zero_length
//
// one request per cycle unless the result stalls; the pipeline is three front stages
// (magnitude, square, sum and branch), one stage per result bit of the
// shift-and-add ratio search, then the output register
// reset is synchronous, active low, and clears control bits only, not data
// a stalled result holds the whole pipeline; nothing is dropped or repeated
module quaternion_axis_remap_core
    import qar_pkg::*;
#(
    parameter int IN_BITS       = IN_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qar_req_if.sink   i_req,
    qar_rsp_if.source o_rsp
);
    localparam int NW  = 2*IN_BITS + 2;
    localparam int AW  = 2*IN_BITS + 2*OUT_FRAC_BITS + 6;
    localparam int RW  = OUT_FRAC_BITS + 1;
    localparam int OW  = OUT_FRAC_BITS + 2;
    localparam int NST = OUT_FRAC_BITS + 1;

    logic          en;
    t_ctl          s_ctl [NST+1];
    logic [NW-1:0] s_n   [NST+1];
    logic [AW-1:0] s_m   [NST+1][LANES];
    logic [AW-1:0] s_a   [NST+1][LANES];
    logic [AW-1:0] s_b   [NST+1][LANES];
    logic [RW-1:0] s_r   [NST+1][LANES];

    logic          r_out_valid;
    logic [OW-1:0] n_out [LANES];
    logic [OW-1:0] r_out [LANES];
    logic          r_zero;

    assign en          = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    qar_front #(
        .IN_BITS       (IN_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_w     (i_req.in_w),
        .i_x     (i_req.in_x),
        .i_y     (i_req.in_y),
        .i_z     (i_req.in_z),
        .o_ctl   (s_ctl[0]),
        .o_n     (s_n[0]),
        .o_m     (s_m[0])
    );

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s_a[0][l] = '0;
            s_b[0][l] = '0;
            s_r[0][l] = '0;
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_step
        qar_step #(
            .IN_BITS       (IN_BITS),
            .OUT_FRAC_BITS (OUT_FRAC_BITS),
            .BIT_POS       (OUT_FRAC_BITS - j)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[j]),
            .i_n     (s_n[j]),
            .i_m     (s_m[j]),
            .i_a     (s_a[j]),
            .i_b     (s_b[j]),
            .i_r     (s_r[j]),
            .o_ctl   (s_ctl[j+1]),
            .o_n     (s_n[j+1]),
            .o_m     (s_m[j+1]),
            .o_a     (s_a[j+1]),
            .o_b     (s_b[j+1]),
            .o_r     (s_r[j+1])
        );
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (s_ctl[NST].zero) begin
                n_out[l] = '0;
            end else if (s_ctl[NST].neg[l]) begin
                n_out[l] = OW'(0) - OW'(s_r[NST][l]);
            end else begin
                n_out[l] = OW'(s_r[NST][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_ctl[NST].valid;
        end
        if (en) begin
            r_out  <= n_out;
            r_zero <= s_ctl[NST].zero;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_w       = r_out[0];
    assign o_rsp.out_x       = r_out[1];
    assign o_rsp.out_y       = r_out[2];
    assign o_rsp.out_z       = r_out[3];
    assign o_rsp.zero_length = r_zero;

endmodule
